/* design/fmsh_pkg.sv */
// Shared constants and types for the folded mid-square decimal hash core.
package fmsh_pkg;

    // Field widths
    localparam int ID_W   = 31;
    localparam int KEY_W  = 10;
    localparam int KD_W   = 2;

    // Decimal digit handling
    localparam int DIGIT_W    = 4;
    localparam int BCD_DIGITS = 10;
    localparam int LO_DIGITS  = 4;
    localparam int HI_DIGITS  = 3;

    // Internal arithmetic widths
    localparam int REV_LO_W = 14;
    localparam int REV_HI_W = 10;
    localparam int FOLD_W   = 14;
    localparam int PROD_W   = 2 * FOLD_W;

    // Reversal runs one step per low-part digit
    localparam int REV_CNT_W = $clog2(LO_DIGITS);
    localparam int POS_W     = $clog2(BCD_DIGITS);

    localparam logic [KD_W-1:0]  KEY_DIGITS_RESET = KD_W'(1);
    localparam logic [KEY_W-1:0] KEY_MAX          = KEY_W'(999);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV_ID,
        ST_REVERSE,
        ST_FOLD,
        ST_SQUARE,
        ST_CONV_SQ,
        ST_KEY,
        ST_DONE
    } fsm_state_t;

endpackage

/* design/fmsh_bcd_conv.sv */
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module fmsh_bcd_conv #(
    parameter int DATA_W = fmsh_pkg::ID_W,
    parameter int DIGITS = fmsh_pkg::BCD_DIGITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [DATA_W-1:0]                     din,
    output logic                                  done,
    output logic [DIGITS*fmsh_pkg::DIGIT_W-1:0]   bcd
);

    localparam int DW    = fmsh_pkg::DIGIT_W;
    localparam int BCD_W = DIGITS * DW;
    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W-1:0] shift_reg, shift_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [BCD_W-1:0]  adj_bcd;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic              busy;

    assign busy = (cnt_reg != '0);

    // Correct every digit that would overflow on the next doubling
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            if (bcd_reg[d*DW +: DW] >= DW'(5)) begin
                adj_bcd[d*DW +: DW] = bcd_reg[d*DW +: DW] + DW'(3);
            end else begin
                adj_bcd[d*DW +: DW] = bcd_reg[d*DW +: DW];
            end
        end
    end

    // Load on start, then shift one binary bit into the digits per cycle
    always_comb begin
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (start) begin
            shift_next = din;
            bcd_next   = '0;
            cnt_next   = CNT_W'(DATA_W);
        end else if (busy) begin
            shift_next = {shift_reg[DATA_W-2:0], 1'b0};
            bcd_next   = {adj_bcd[BCD_W-2:0], shift_reg[DATA_W-1]};
            cnt_next   = cnt_reg - CNT_W'(1);
            done_next  = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

/* design/fmsh_ser_mult.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module fmsh_ser_mult #(
    parameter int OP_W = fmsh_pkg::FOLD_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [OP_W-1:0]     op_a,
    input  logic [OP_W-1:0]     op_b,
    output logic                done,
    output logic [2*OP_W-1:0]   product
);

    localparam int P_W   = 2 * OP_W;
    localparam int CNT_W = $clog2(OP_W + 1);

    logic [P_W-1:0]   mcand_reg, mcand_next;
    logic [OP_W-1:0]  mplier_reg, mplier_next;
    logic [P_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    // Add the shifted multiplicand for each set multiplier bit, LSB first
    always_comb begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        if (start) begin
            mcand_next  = P_W'(op_a);
            mplier_next = op_b;
            acc_next    = '0;
            cnt_next    = CNT_W'(OP_W);
        end else if (cnt_reg != '0) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[P_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[OP_W-1:1]};
            cnt_next    = cnt_reg - CNT_W'(1);
            done_next   = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

/* design/fold_mid_square_decimal_hash_core.sv */
// Top level: sequencer, digit reversal, key digit pick and result register.
// From accept to m_valid an ID passes two 31-step BCD conversions,
//   four reversal steps, a 14-step serial square and zero to three key digits.
// The next ID is taken only once the last result sits in the output register,
//   so the serial steps above and any stall on the result side set the rate.
// Reset: synchronous active low; key_digits returns to 1, output is empty.
module fold_mid_square_decimal_hash_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [fmsh_pkg::ID_W-1:0]   s_student_id,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [fmsh_pkg::KEY_W-1:0]  m_hash_key,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fmsh_pkg::KD_W-1:0]   cfg_key_digits
);

    localparam int DW     = fmsh_pkg::DIGIT_W;
    localparam int BCD_W  = fmsh_pkg::BCD_DIGITS * DW;
    localparam int LO_W   = fmsh_pkg::LO_DIGITS * DW;
    localparam int HI_W   = fmsh_pkg::HI_DIGITS * DW;
    localparam int ID_W   = fmsh_pkg::ID_W;
    localparam int KEY_W  = fmsh_pkg::KEY_W;
    localparam int KD_W   = fmsh_pkg::KD_W;
    localparam int POS_W  = fmsh_pkg::POS_W;
    localparam int RC_W   = fmsh_pkg::REV_CNT_W;
    localparam int RLO_W  = fmsh_pkg::REV_LO_W;
    localparam int RHI_W  = fmsh_pkg::REV_HI_W;
    localparam int FOLD_W = fmsh_pkg::FOLD_W;
    localparam int PROD_W = fmsh_pkg::PROD_W;

    fmsh_pkg::fsm_state_t state_reg, state_next;

    logic [KD_W-1:0]   key_digits_reg;
    logic              m_valid_reg;
    logic [KEY_W-1:0]  m_key_reg;

    logic [LO_W-1:0]   lo_sh_reg;
    logic [HI_W-1:0]   hi_sh_reg;
    logic [RLO_W-1:0]  rev_lo_reg, rev_lo_next;
    logic [RHI_W-1:0]  rev_hi_reg, rev_hi_next;
    logic [RC_W-1:0]   rev_cnt_reg;

    logic [POS_W-1:0]  pos_reg;
    logic [KD_W-1:0]   kcnt_reg;
    logic              exh_reg;
    logic [KEY_W-1:0]  key_reg, key_next;

    logic              conv_start, conv_done;
    logic [ID_W-1:0]   conv_din;
    logic [BCD_W-1:0]  bcd;
    logic              mult_start, mult_done;
    logic [PROD_W-1:0] product;
    logic [FOLD_W-1:0] folded;

    logic [POS_W-1:0]  top_idx;
    logic [POS_W-1:0]  start_pos;
    logic [DW-1:0]     key_digit;
    logic              key_end;
    logic              out_free;

    // Serial converter, shared by the ID and the square
    fmsh_bcd_conv #(
        .DATA_W (ID_W),
        .DIGITS (fmsh_pkg::BCD_DIGITS)
    ) u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (conv_start),
        .din     (conv_din),
        .done    (conv_done),
        .bcd     (bcd)
    );

    // Serial squarer
    fmsh_ser_mult #(
        .OP_W (FOLD_W)
    ) u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mult_start),
        .op_a    (folded),
        .op_b    (folded),
        .done    (mult_done),
        .product (product)
    );

    assign folded    = FOLD_W'(rev_hi_reg) + FOLD_W'(rev_lo_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign key_end   = (kcnt_reg == '0) || exh_reg;
    assign key_digit = bcd[{pos_reg, 2'b00} +: DW];

    // Locate the most significant nonzero digit of the square
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < fmsh_pkg::BCD_DIGITS; i++) begin
            if (bcd[i*DW +: DW] != '0) begin
                top_idx = POS_W'(i);
            end
        end
        start_pos = top_idx - (top_idx >> 1);
    end

    // Reverse both parts, one digit per step, stopping at leading zeros
    always_comb begin
        rev_lo_next = rev_lo_reg;
        rev_hi_next = rev_hi_reg;
        if (lo_sh_reg != '0) begin
            rev_lo_next = (rev_lo_reg << 3) + (rev_lo_reg << 1)
                        + RLO_W'(lo_sh_reg[DW-1:0]);
        end
        if (hi_sh_reg != '0) begin
            rev_hi_next = (rev_hi_reg << 3) + (rev_hi_reg << 1)
                        + RHI_W'(hi_sh_reg[DW-1:0]);
        end
    end

    // Append one square digit to the key
    assign key_next = (key_reg << 3) + (key_reg << 1) + KEY_W'(key_digit);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fmsh_pkg::ST_IDLE: begin
                if (s_valid) state_next = fmsh_pkg::ST_CONV_ID;
            end
            fmsh_pkg::ST_CONV_ID: begin
                if (conv_done) state_next = fmsh_pkg::ST_REVERSE;
            end
            fmsh_pkg::ST_REVERSE: begin
                if (rev_cnt_reg == RC_W'(fmsh_pkg::LO_DIGITS - 1)) begin
                    state_next = fmsh_pkg::ST_FOLD;
                end
            end
            fmsh_pkg::ST_FOLD: begin
                state_next = fmsh_pkg::ST_SQUARE;
            end
            fmsh_pkg::ST_SQUARE: begin
                if (mult_done) state_next = fmsh_pkg::ST_CONV_SQ;
            end
            fmsh_pkg::ST_CONV_SQ: begin
                if (conv_done) state_next = fmsh_pkg::ST_KEY;
            end
            fmsh_pkg::ST_KEY: begin
                if (key_end) state_next = fmsh_pkg::ST_DONE;
            end
            fmsh_pkg::ST_DONE: begin
                if (out_free) state_next = fmsh_pkg::ST_IDLE;
            end
            default: state_next = fmsh_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_ready    = 1'b0;
        conv_start = 1'b0;
        conv_din   = s_student_id;
        mult_start = 1'b0;
        unique case (state_reg)
            fmsh_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                conv_start = s_valid;
            end
            fmsh_pkg::ST_FOLD: begin
                mult_start = 1'b1;
            end
            fmsh_pkg::ST_SQUARE: begin
                conv_start = mult_done;
                conv_din   = {{(ID_W - PROD_W){1'b0}}, product};
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // State, configuration and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= fmsh_pkg::ST_IDLE;
            key_digits_reg <= fmsh_pkg::KEY_DIGITS_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                key_digits_reg <= cfg_key_digits;
            end
            if (state_reg == fmsh_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == fmsh_pkg::ST_DONE && out_free) begin
            m_key_reg <= key_reg;
        end
        // capture the two parts of the last seven digits
        if (state_reg == fmsh_pkg::ST_CONV_ID && conv_done) begin
            lo_sh_reg   <= bcd[LO_W-1:0];
            hi_sh_reg   <= bcd[LO_W +: HI_W];
            rev_lo_reg  <= '0;
            rev_hi_reg  <= '0;
            rev_cnt_reg <= '0;
        end
        // advance the reversal
        if (state_reg == fmsh_pkg::ST_REVERSE) begin
            lo_sh_reg   <= lo_sh_reg >> DW;
            hi_sh_reg   <= hi_sh_reg >> DW;
            rev_lo_reg  <= rev_lo_next;
            rev_hi_reg  <= rev_hi_next;
            rev_cnt_reg <= rev_cnt_reg + RC_W'(1);
        end
        // set up the key pick at the middle digit
        if (state_reg == fmsh_pkg::ST_CONV_SQ && conv_done) begin
            pos_reg  <= start_pos;
            kcnt_reg <= key_digits_reg;
            exh_reg  <= 1'b0;
            key_reg  <= '0;
        end
        // take one digit, stop at the end of the square
        if (state_reg == fmsh_pkg::ST_KEY && !key_end) begin
            key_reg  <= key_next;
            kcnt_reg <= kcnt_reg - KD_W'(1);
            if (pos_reg == '0) begin
                exh_reg <= 1'b1;
            end else begin
                pos_reg <= pos_reg - POS_W'(1);
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_hash_key = m_key_reg;
    assign cfg_ready  = 1'b1;

    // Accepted ID starts the first conversion
    a_accept_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == fmsh_pkg::ST_CONV_ID)
        else $error("accepted ID did not start conversion");

    // Key never exceeds three decimal digits
    a_key_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hash_key <= fmsh_pkg::KEY_MAX)
        else $error("hash key out of range");

    // Converter finishes only while the sequencer waits on it
    a_conv_done: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_done |-> (state_reg == fmsh_pkg::ST_CONV_ID ||
                       state_reg == fmsh_pkg::ST_CONV_SQ))
        else $error("unexpected converter completion");

    // Multiplier finishes only during the square step
    a_mult_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mult_done |-> state_reg == fmsh_pkg::ST_SQUARE)
        else $error("unexpected multiplier completion");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the folded mid-square decimal hash core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_W  = fmsh_pkg::ID_W;
    localparam int KEY_W = fmsh_pkg::KEY_W;
    localparam int KD_W  = fmsh_pkg::KD_W;

    localparam int unsigned ID_MOD    = 10_000_000;
    localparam int unsigned SPLIT_MOD = 10_000;
    localparam int unsigned RADIX     = 10;

    localparam int RESET_CYCLES   = 7;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 120;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [ID_W-1:0]   s_student_id   = '0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [KEY_W-1:0]  m_hash_key;
    logic              cfg_valid      = 1'b0;
    logic              cfg_ready;
    logic [KD_W-1:0]   cfg_key_digits = '0;

    // Scoreboard state
    logic [KD_W-1:0]   key_digits_now = fmsh_pkg::KEY_DIGITS_RESET;
    logic [KEY_W-1:0]  pending_keys[$];
    logic [KEY_W-1:0]  expected_key;
    int                mismatches  = 0;
    int                idle_cycles = 0;
    bit                quiet       = 1'b0;
    bit                hold_req    = 1'b0;

    fold_mid_square_decimal_hash_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_student_id   (s_student_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash_key     (m_hash_key),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_key_digits (cfg_key_digits)
    );

    always #1 aclk = ~aclk;

    function automatic int unsigned reverse_digits(input int unsigned v);
        int unsigned r;
        r = 0;
        while (v > 0) begin
            r = r * RADIX + v % RADIX;
            v = v / RADIX;
        end
        return r;
    endfunction

    // Fold the last seven digits, square, and pick the middle decimal digits
    function automatic logic [KEY_W-1:0] fold_mid_square(input logic [ID_W-1:0] id,
                                                         input logic [KD_W-1:0] kd);
        int unsigned      low7;
        int unsigned      folded;
        int unsigned      key;
        int unsigned      mid;
        int unsigned      len;
        int unsigned      i;
        longint unsigned  sq;
        int unsigned      digit_lsf[12];
        low7   = {1'b0, id} % ID_MOD;
        folded = reverse_digits(low7 / SPLIT_MOD) + reverse_digits(low7 % SPLIT_MOD);
        sq     = folded;
        sq     = sq * sq;
        // split into digits, least significant first; zero is one digit
        len = 0;
        do begin
            digit_lsf[len] = 32'(sq % RADIX);
            sq  = sq / RADIX;
            len = len + 1;
        end while (sq > 0);
        mid = (len - 1) / 2;
        key = 0;
        for (i = 0; i < kd && mid + i < len; i++)
            key = key * RADIX + digit_lsf[len - 1 - mid - i];
        return key[KEY_W-1:0];
    endfunction

    // Track the register, queue predictions, and check each result transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            key_digits_now = fmsh_pkg::KEY_DIGITS_RESET;
        end else begin
            if (cfg_valid && cfg_ready)
                key_digits_now = cfg_key_digits;
            if (s_valid && s_ready)
                pending_keys.push_back(fold_mid_square(s_student_id, key_digits_now));
            if (m_valid && m_ready) begin
                if (pending_keys.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected hash_key %0d with nothing pending", m_hash_key);
                end else begin
                    expected_key = pending_keys.pop_front();
                    if (m_hash_key !== expected_key) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("hash_key mismatch: expected %0d, got %0d",
                                     expected_key, m_hash_key);
                    end
                end
            end
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, one long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one ID, with an optional gap first, and wait for its transaction
    task automatic send_id(input logic [ID_W-1:0] id);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_student_id <= id;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic stop_ids();
        s_valid <= 1'b0;
    endtask

    // Write key_digits once every pending result has drained
    task automatic write_key_digits(input logic [KD_W-1:0] kd);
        do @(posedge aclk); while (pending_keys.size() != 0);
        cfg_valid      <= 1'b1;
        cfg_key_digits <= kd;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Hash with the reset value of key_digits, before any write
    task automatic test_reset_setting();
        send_id(ID_W'(23));
        send_id(ID_W'(9_999_999));
        send_id({ID_W{1'b1}});
        send_id('0);
        stop_ids();
    endtask

    // Zero digits, short and zero squares, leading zeros in the key, trailing zeros
    task automatic test_corner_ids();
        write_key_digits(KD_W'(0));
        send_id(ID_W'(9_999_999));
        send_id(ID_W'(23));
        stop_ids();
        write_key_digits(KD_W'(3));
        send_id(ID_W'(1));
        send_id(ID_W'(3));
        send_id(ID_W'(23));
        send_id(ID_W'(120));
        send_id(ID_W'(9_999_999));
        send_id(ID_W'(10_000_000));
        send_id(ID_W'(2_140_000_000));
        send_id({ID_W{1'b1}});
        stop_ids();
        write_key_digits(KD_W'(2));
        send_id(ID_W'(23));
        send_id(ID_W'(4_321));
        send_id('0);
        stop_ids();
    endtask

    // Random IDs: full range, short values, seven-digit values, trailing zeros
    task automatic test_random_ids(input logic [KD_W-1:0] kd, input int count);
        logic [ID_W-1:0] id;
        write_key_digits(kd);
        repeat (count) begin
            case ($urandom_range(0, 3))
                0:       id = ID_W'($urandom);
                1:       id = ID_W'($urandom_range(0, 9_999));
                2:       id = ID_W'($urandom_range(0, ID_MOD - 1));
                default: id = ID_W'($urandom_range(0, 214_748_364) * 10);
            endcase
            send_id(id);
        end
        stop_ids();
    endtask

    // Hold the result side off while IDs keep coming, so the input stalls
    task automatic test_output_stall();
        write_key_digits(KD_W'(3));
        hold_req = 1'b1;
        repeat (12) send_id(ID_W'($urandom));
        stop_ids();
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_no_idling();
        do @(posedge aclk); while (pending_keys.size() != 0);
        quiet = 1'b1;
        test_random_ids(KD_W'(3), 100);
        test_random_ids(KD_W'(1), 50);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_setting();
        test_corner_ids();
        test_random_ids(KD_W'(2), 180);
        test_random_ids(KD_W'(0), 100);
        test_random_ids(KD_W'(3), 160);
        test_random_ids(KD_W'(1), 140);
        test_output_stall();
        test_no_idling();
        // drain, then let the pipeline settle
        do @(posedge aclk); while (pending_keys.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

/* files.f */
design/fmsh_pkg.sv
design/fmsh_bcd_conv.sv
design/fmsh_ser_mult.sv
design/fold_mid_square_decimal_hash_core.sv
sim/testbench.sv
